// ----- rtl/core/apt_pkg.sv -----
// Package with the shared types, codes and reset values of the auto power-off timer.
`timescale 1ns / 1ps

package apt_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned ModeCodeW = 2;

  localparam logic [CfgIdxW-1:0] CFG_FINE_LIMIT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WARN_LIMIT  = 2'd2;

  localparam logic [CountW-1:0] FINE_LIMIT_RST  = 8'd150;
  localparam logic [CountW-1:0] COUNT_LIMIT_RST = 8'd18;
  localparam logic [CountW-1:0] WARN_LIMIT_RST  = 8'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  localparam logic [ModeCodeW-1:0] MODE_CODE_COUNTING = 2'd0;
  localparam logic [ModeCodeW-1:0] MODE_CODE_WARNING  = 2'd1;
  localparam logic [ModeCodeW-1:0] MODE_CODE_OFF      = 2'd2;

  typedef enum logic [2:0] {
    MODE_COUNTING = 3'b001,
    MODE_WARNING  = 3'b010,
    MODE_OFF      = 3'b100
  } mode_e;

  typedef struct packed {
    logic op;
    logic button_level;
  } apt_in_t;

  typedef struct packed {
    logic [ModeCodeW-1:0] mode;
    logic                 power_enable;
    logic                 warn_led;
    logic                 sleep_enable;
    logic                 press_accepted;
  } apt_out_t;

  typedef struct packed {
    logic [CountW-1:0] fine_limit;
    logic [CountW-1:0] count_limit;
    logic [CountW-1:0] warn_limit;
  } apt_cfg_t;

  function automatic logic [ModeCodeW-1:0] mode_code(mode_e m);
    logic [ModeCodeW-1:0] c;
    unique case (m)
      MODE_COUNTING: c = MODE_CODE_COUNTING;
      MODE_WARNING:  c = MODE_CODE_WARNING;
      MODE_OFF:      c = MODE_CODE_OFF;
      default:       c = MODE_CODE_OFF;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/apt_cfg_regs.sv -----
// Configuration register file holding the three timer limits.
`timescale 1ns / 1ps

module apt_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [apt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [apt_pkg::CfgDataW-1:0]  cfg_data_i,
  output apt_pkg::apt_cfg_t             cfg_o
);
  import apt_pkg::*;

  apt_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FINE_LIMIT:  cfg_d.fine_limit  = cfg_data_i;
        CFG_COUNT_LIMIT: cfg_d.count_limit = cfg_data_i;
        CFG_WARN_LIMIT:  cfg_d.warn_limit  = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fine_limit  <= FINE_LIMIT_RST;
      cfg_q.count_limit <= COUNT_LIMIT_RST;
      cfg_q.warn_limit  <= WARN_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/apt_core.sv -----
// Timer state registers and the single-pass update for one event.
`timescale 1ns / 1ps

module apt_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  apt_pkg::apt_in_t   in_i,
  input  apt_pkg::apt_cfg_t  cfg_i,
  output apt_pkg::apt_out_t  res_o
);
  import apt_pkg::*;

  mode_e             mode_q, mode_d;
  logic [CountW-1:0] fine_q, fine_d;
  logic [CountW-1:0] coarse_q, coarse_d;
  logic              pend_q, pend_d;
  logic              edge_en_q, edge_en_d;
  logic              warn_q, warn_d;
  logic              power_q, power_d;
  logic              sleep_q, sleep_d;
  logic              accepted;
  logic              fine_wrap;
  logic [CountW-1:0] fine_n, coarse_n;

  // Counter advance of a normal tick.
  assign fine_wrap = (fine_q == cfg_i.fine_limit);
  assign fine_n    = fine_wrap ? '0 : fine_q + 1'b1;
  assign coarse_n  = fine_wrap ? coarse_q + 1'b1 : coarse_q;

  always_comb begin
    mode_d    = mode_q;
    fine_d    = fine_q;
    coarse_d  = coarse_q;
    pend_d    = pend_q;
    edge_en_d = edge_en_q;
    warn_d    = warn_q;
    power_d   = power_q;
    sleep_d   = sleep_q;
    accepted  = 1'b0;
    if (fire_i) begin
      if (in_i.op == OP_EDGE) begin
        if (edge_en_q) begin
          edge_en_d = 1'b0;
          pend_d    = 1'b1;
        end
      end else if (pend_q) begin
        // The tick is spent on the press check.
        pend_d = 1'b0;
        if (in_i.button_level) begin
          accepted = 1'b1;
          unique case (mode_q)
            MODE_COUNTING: begin
              power_d = 1'b0;
              mode_d  = MODE_OFF;
            end
            MODE_WARNING: begin
              sleep_d  = 1'b1;
              fine_d   = '0;
              coarse_d = '0;
              mode_d   = MODE_COUNTING;
            end
            default: mode_d = mode_q;
          endcase
        end
      end else begin
        if (!in_i.button_level) edge_en_d = 1'b1;
        unique case (mode_q)
          MODE_COUNTING: begin
            fine_d   = fine_n;
            coarse_d = coarse_n;
            if (coarse_n == cfg_i.count_limit) begin
              fine_d   = '0;
              coarse_d = '0;
              mode_d   = MODE_WARNING;
            end
          end
          MODE_WARNING: begin
            fine_d   = fine_n;
            coarse_d = coarse_n;
            warn_d   = ~warn_q;
            sleep_d  = ~fine_n[1];
            if (coarse_n == cfg_i.warn_limit) begin
              sleep_d = 1'b1;
              power_d = 1'b0;
              mode_d  = MODE_OFF;
            end
          end
          default: mode_d = mode_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_COUNTING;
      fine_q    <= '0;
      coarse_q  <= '0;
      pend_q    <= 1'b0;
      edge_en_q <= 1'b1;
      warn_q    <= 1'b0;
      power_q   <= 1'b1;
      sleep_q   <= 1'b1;
    end else begin
      mode_q    <= mode_d;
      fine_q    <= fine_d;
      coarse_q  <= coarse_d;
      pend_q    <= pend_d;
      edge_en_q <= edge_en_d;
      warn_q    <= warn_d;
      power_q   <= power_d;
      sleep_q   <= sleep_d;
    end
  end

  always_comb begin
    res_o.mode           = mode_code(mode_d);
    res_o.power_enable   = power_d;
    res_o.warn_led       = warn_d;
    res_o.sleep_enable   = sleep_d;
    res_o.press_accepted = accepted;
  end

endmodule

// ----- rtl/core/apt_out_slot.sv -----
// Result register that holds one finished result until the consumer takes it.
`timescale 1ns / 1ps

module apt_out_slot (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  apt_pkg::apt_out_t  res_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output apt_pkg::apt_out_t  out_data_o,
  output logic               free_o
);
  import apt_pkg::*;

  logic     valid_q, valid_d;
  apt_out_t data_q;

  // The slot can take a new result when empty or when drained this cycle.
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- rtl/core/auto_power_off_timer.sv -----
// Top level of the auto power-off timer with a warning phase.
// A result is loaded into the output register in the cycle after its event is accepted.
// Throughput: one event per cycle; the state update is one combinational pass per event.
// The only stall comes from the single-entry output register when its result is not taken.
// Reset (rst_ni low, asynchronous): counting mode, counters zero, edges enabled, supply on,
// sleep allowed, limits back to 150, 18 and 2, and the output register empty.
`timescale 1ns / 1ps

module auto_power_off_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  apt_pkg::apt_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output apt_pkg::apt_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [apt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [apt_pkg::CfgDataW-1:0]  cfg_data_i
);
  import apt_pkg::*;

  apt_cfg_t cfg;
  apt_out_t res;
  logic     in_fire;
  logic     slot_free;

  // An event transaction completes when the output register can hold its
  // result, so an event is taken every cycle while the consumer keeps up.
  assign in_ready_o = slot_free;
  assign in_fire    = in_valid_i && slot_free;

  apt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Debounce, counters and mode all update in one pass on the accepted
  // event; the result reflects the state after that event.
  apt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .in_i   (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  apt_out_slot u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .free_o      (slot_free)
  );

  // The supply is dropped exactly when the block is in off mode.
  a_power_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.power_enable == (out_data_o.mode != MODE_CODE_OFF)))
    else $error("power_enable disagrees with mode");

  // A button edge transaction never reports an accepted press.
  a_edge_no_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.op == OP_EDGE) |=> !out_data_o.press_accepted)
    else $error("press reported on an edge event");

  // Off mode is terminal: the result after an off result is off too.
  a_off_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.mode == MODE_CODE_OFF && in_fire)
      |=> (out_data_o.mode == MODE_CODE_OFF))
    else $error("left off mode");

endmodule
